// ===== rtl/core/mbp_pkg.sv =====
// Package with the shared types and constants of the multipart body parser.
package mbp_pkg;

	typedef enum logic [4:0] {
		ST_PREAMBLE, ST_PRE_HY, ST_FIRST_BND, ST_HF_START, ST_HF, ST_HV_START, ST_HV,
		ST_HV_CR, ST_HDRS_DONE, ST_DATA, ST_DATA_CR, ST_DATA_CRLF, ST_DATA_CRLF_HY,
		ST_DATA_BND, ST_BND_DONE, ST_BND_DONE_CR, ST_BND_DONE_HY, ST_EPILOGUE, ST_ERROR
	} parse_state_t;

	typedef enum logic [3:0] {
		EV_DATA = 4'd0, EV_HNAME = 4'd1, EV_HVALUE = 4'd2, EV_BODY_BEGIN = 4'd3,
		EV_PART_BEGIN = 4'd4, EV_HDRS_DONE = 4'd5, EV_PART_END = 4'd6,
		EV_BODY_END = 4'd7, EV_ERROR = 4'd8
	} event_kind_t;

	// Prefix that the front end asks the back end to replay before the
	// ordinary results of a byte.
	typedef enum logic [2:0] {
		RP_NONE, RP_CR, RP_CRLF, RP_CRLFHY, RP_BND
	} replay_t;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_LEN = 3'd0;

	// One classified word from the front end. Up to two event results follow
	// the replayed prefix; an error result comes last.
	typedef struct packed {
		replay_t     replay;
		logic [5:0]  replay_len;
		logic        ev0_valid;
		event_kind_t ev0_kind;
		logic [7:0]  ev0_byte;
		logic        ev1_valid;
		event_kind_t ev1_kind;
		logic        err;
		logic [31:0] err_offset;
	} cmd_t;

	function automatic logic name_char(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h30) && (c <= 8'h39));
		case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
			8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/mbp_front.sv =====
// Front end: parse state machine that classifies each byte into one command word.
module mbp_front #(
	parameter int unsigned MAX_BOUNDARY = 56
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                chunk_last,
	input  logic [5:0]          eff_len,
	input  logic [8*MAX_BOUNDARY-1:0] bnd,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output mbp_pkg::cmd_t       cmd
);
	import mbp_pkg::*;

	parse_state_t state_q, state_d;
	logic [5:0]   match_q, match_d;
	logic [31:0]  offset_q;
	logic         err;

	function automatic logic [7:0] bbyte(input logic [8*MAX_BOUNDARY-1:0] b,
		input logic [5:0] i);
		logic [7:0] r;
		r = 8'd0;
		for (int k = 0; k < MAX_BOUNDARY; k++) begin
			if (i == 6'(k)) r = b[8*k +: 8];
		end
		return r;
	endfunction

	logic [7:0] bm;
	assign bm = bbyte(bnd, match_q);

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;

	// The redo chains of the byte loop are at most a few states deep, so each
	// state settles its own follow-on state in one pass below.
	always_comb begin
		logic       hy, ist;
		parse_state_t nx;
		state_d = state_q;
		match_d = match_q;
		err = 1'b0;
		cmd = '0;
		cmd.replay = RP_NONE;
		cmd.ev0_kind = EV_DATA;
		cmd.ev1_kind = EV_DATA;
		hy = 1'b0;
		ist = 1'b0;
		nx = ST_DATA;
		unique case (state_q)
			ST_PREAMBLE: if (in_byte == CH_HYPHEN) state_d = ST_PRE_HY;
			ST_PRE_HY: begin
				state_d = (in_byte == CH_HYPHEN) ? ST_FIRST_BND : ST_PREAMBLE;
				match_d = '0;
			end
			ST_FIRST_BND: begin
				if (match_q == eff_len) begin
					if (in_byte != CH_CR) err = 1'b1;
					else match_d = match_q + 6'd1;
				end else if (match_q == eff_len + 6'd1) begin
					if (in_byte != CH_LF) err = 1'b1;
					else begin
						cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_BODY_BEGIN;
						cmd.ev1_valid = 1'b1; cmd.ev1_kind = EV_PART_BEGIN;
						match_d = '0;
						state_d = ST_HF_START;
					end
				end else if (match_q < eff_len && in_byte == bm) begin
					match_d = match_q + 6'd1;
				end else err = 1'b1;
			end
			ST_HF_START, ST_HF: begin
				if (state_q == ST_HF_START && in_byte == CH_CR) state_d = ST_HDRS_DONE;
				else if (name_char(in_byte)) begin
					state_d = ST_HF;
					cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_HNAME;
					cmd.ev0_byte = in_byte;
				end else if (in_byte == CH_COLON) state_d = ST_HV_START;
				else err = 1'b1;
			end
			ST_HV_START, ST_HV: begin
				if (state_q == ST_HV_START &&
					(in_byte == CH_SPACE || in_byte == CH_TAB)) state_d = ST_HV_START;
				else if (in_byte == CH_CR) state_d = ST_HV_CR;
				else begin
					state_d = ST_HV;
					cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_HVALUE;
					cmd.ev0_byte = in_byte;
				end
			end
			ST_HV_CR: begin
				if (in_byte == CH_LF) state_d = ST_HF_START;
				else err = 1'b1;
			end
			ST_HDRS_DONE: begin
				if (in_byte == CH_LF) begin
					cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_HDRS_DONE;
					state_d = ST_DATA;
				end else err = 1'b1;
			end
			ST_DATA, ST_DATA_CR, ST_DATA_CRLF, ST_DATA_CRLF_HY: begin
				// The byte that advances the CR-LF-hyphen chain; anything else
				// replays the chain and falls back to plain data.
				unique case (state_q)
					ST_DATA:        begin hy = (in_byte == CH_CR);     nx = ST_DATA_CR; end
					ST_DATA_CR:     begin hy = (in_byte == CH_LF);     nx = ST_DATA_CRLF; end
					ST_DATA_CRLF:   begin hy = (in_byte == CH_HYPHEN); nx = ST_DATA_CRLF_HY; end
					default:        begin hy = (in_byte == CH_HYPHEN); nx = ST_DATA_BND; end
				endcase
				if (hy) begin
					state_d = nx;
					if (state_q == ST_DATA_CRLF_HY) match_d = '0;
				end else begin
					unique case (state_q)
						ST_DATA_CR:   cmd.replay = RP_CR;
						ST_DATA_CRLF: cmd.replay = RP_CRLF;
						ST_DATA_CRLF_HY: cmd.replay = RP_CRLFHY;
						default: cmd.replay = RP_NONE;
					endcase
					if (in_byte == CH_CR) state_d = ST_DATA_CR;
					else begin
						state_d = ST_DATA;
						cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_DATA;
						cmd.ev0_byte = in_byte;
					end
				end
			end
			ST_DATA_BND, ST_BND_DONE: begin
				ist = (state_q == ST_BND_DONE) || (match_q >= eff_len);
				if (ist) begin
					match_d = '0;
					if (in_byte == CH_CR) state_d = ST_BND_DONE_CR;
					else if (in_byte == CH_HYPHEN) state_d = ST_BND_DONE_HY;
					else err = 1'b1;
				end else if (in_byte == bm) begin
					match_d = match_q + 6'd1;
				end else begin
					cmd.replay = RP_BND;
					cmd.replay_len = match_q;
					match_d = '0;
					if (in_byte == CH_CR) state_d = ST_DATA_CR;
					else begin
						state_d = ST_DATA;
						cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_DATA;
						cmd.ev0_byte = in_byte;
					end
				end
			end
			ST_BND_DONE_CR: begin
				if (in_byte == CH_LF) begin
					cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_PART_END;
					cmd.ev1_valid = 1'b1; cmd.ev1_kind = EV_PART_BEGIN;
					state_d = ST_HF_START;
				end else err = 1'b1;
			end
			ST_BND_DONE_HY: begin
				if (in_byte == CH_HYPHEN) begin
					cmd.ev0_valid = 1'b1; cmd.ev0_kind = EV_PART_END;
					cmd.ev1_valid = 1'b1; cmd.ev1_kind = EV_BODY_END;
					state_d = ST_EPILOGUE;
				end else err = 1'b1;
			end
			ST_EPILOGUE: ;
			ST_ERROR: begin
				cmd = '0;
				cmd.replay = RP_NONE;
				cmd.ev0_kind = EV_DATA;
				cmd.ev1_kind = EV_DATA;
				err = 1'b1;
			end
			default: err = 1'b1;
		endcase
		if (err) begin
			state_d = ST_ERROR;
			cmd.err = 1'b1;
			cmd.err_offset = offset_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_PREAMBLE;
			match_q  <= '0;
			offset_q <= '0;
		end else if (in_valid && cmd_ready) begin
			state_q <= state_d;
			match_q <= match_d;
			if (!err) offset_q <= chunk_last ? 32'd0 : offset_q + 32'd1;
		end
	end

endmodule

// ===== rtl/core/mbp_queue.sv =====
// Short command queue between the front end and the back end.
module mbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  mbp_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output mbp_pkg::cmd_t rd_data
);
	import mbp_pkg::*;

	cmd_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q, wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ===== rtl/core/mbp_back.sv =====
// Back end: sequencer that expands one command word into its result words.
module mbp_back #(
	parameter int unsigned MAX_BOUNDARY = 56
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  mbp_pkg::cmd_t       cmd,
	input  logic [8*MAX_BOUNDARY-1:0] bnd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          event_kind,
	output logic [7:0]          out_byte,
	output logic [31:0]         error_offset,
	output logic                run_last
);
	import mbp_pkg::*;

	// Step 0..3 walk "\r\n--", 4+i the boundary prefix, then ev0, ev1, err.
	localparam int unsigned SW = 7;
	localparam logic [SW-1:0] S_PFX  = 7'd4;
	localparam logic [SW-1:0] S_EV0  = 7'd64;
	localparam logic [SW-1:0] S_EV1  = 7'd65;
	localparam logic [SW-1:0] S_ERR  = 7'd66;
	localparam logic [SW-1:0] S_DONE = 7'd67;

	logic [SW-1:0] step_q, cur, nxt;
	logic          have, emit;
	logic [3:0]    k;
	logic [7:0]    b;
	logic [31:0]   o;
	logic [5:0]    pidx;
	logic [7:0]    pbyte;

	// Next step that produces a result, from a given candidate.
	function automatic logic [SW-1:0] seek(input logic [SW-1:0] s, input cmd_t c);
		logic [SW-1:0] r;
		logic [2:0]    plen;
		r = s;
		unique case (c.replay)
			RP_CR:     plen = 3'd1;
			RP_CRLF:   plen = 3'd2;
			RP_CRLFHY: plen = 3'd3;
			RP_BND:    plen = 3'd4;
			default:   plen = 3'd0;
		endcase
		if (r < S_PFX && r >= {4'd0, plen}) r = S_PFX;
		if (r >= S_PFX && r < S_EV0 &&
			(c.replay != RP_BND || (r - S_PFX) >= {1'b0, c.replay_len})) r = S_EV0;
		if (r == S_EV0 && !c.ev0_valid) r = S_EV1;
		if (r == S_EV1 && !c.ev1_valid) r = S_ERR;
		if (r == S_ERR && !c.err) r = S_DONE;
		return r;
	endfunction

	assign pidx = 6'(step_q - S_PFX);
	always_comb begin
		pbyte = 8'd0;
		for (int i = 0; i < MAX_BOUNDARY; i++) begin
			if (pidx == 6'(i)) pbyte = bnd[8*i +: 8];
		end
	end

	assign cur  = seek(step_q, cmd);
	assign have = cmd_valid && (cur != S_DONE);
	assign nxt  = seek(cur + 7'd1, cmd);

	always_comb begin
		k = EV_DATA;
		b = 8'd0;
		o = 32'd0;
		if (cur == 7'd0) b = CH_CR;
		else if (cur == 7'd1) b = CH_LF;
		else if (cur < S_PFX) b = CH_HYPHEN;
		else if (cur < S_EV0) b = pbyte;
		else if (cur == S_EV0) begin
			k = cmd.ev0_kind;
			b = (cmd.ev0_kind == EV_DATA || cmd.ev0_kind == EV_HNAME ||
				cmd.ev0_kind == EV_HVALUE) ? cmd.ev0_byte : 8'd0;
		end else if (cur == S_EV1) k = cmd.ev1_kind;
		else begin
			k = EV_ERROR;
			o = cmd.err_offset;
		end
	end

	// Output register: a result waits here while the sequencer stands still.
	logic oe;
	assign oe   = !out_valid || out_ready;
	assign emit = have && oe;
	// pbyte is read on step_q, which must already sit at the prefix step.
	logic pfx_wait;
	assign pfx_wait = (cur >= S_PFX) && (cur < S_EV0) && (cur != step_q);
	assign cmd_ready = cmd_valid && oe && !pfx_wait && (cur == S_DONE || nxt == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (oe) out_valid <= emit && !pfx_wait;
			if (cmd_ready) step_q <= '0;
			else if (pfx_wait) step_q <= cur;
			else if (emit) step_q <= cur + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !pfx_wait) begin
			event_kind   <= k;
			out_byte     <= b;
			error_offset <= o;
			run_last     <= (nxt == S_DONE);
		end
	end

endmodule

// ===== rtl/core/multipart_body_parser_unit.sv =====
// Top level of the multipart body parser: configuration registers, front end, queue, back end.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | in_valid/in_ready   | in_byte, chunk_last
//  result   | out_valid/out_ready | event_kind, out_byte, error_offset, run_last
//  config   | cfg_we              | cfg_index, cfg_data (write only)
//
// The front end takes one byte per cycle while the queue has room. The back
// end issues the result words in order and holds each while out_ready is low; a
// byte with several results (a boundary replay can give up to 60) holds the
// head of the queue until its last result is issued. Reset returns the parser
// to the preamble and clears the byte offset counter. A stalled result side
// fills the two-entry queue and then holds in_ready low.
module multipart_body_parser_unit #(
	parameter int unsigned MAX_BOUNDARY = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        chunk_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [7:0]  out_byte,
	output logic [31:0] error_offset,
	output logic        run_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import mbp_pkg::*;

	logic [5:0]  len_q;
	logic [63:0] word_q [7];
	logic [5:0]  eff_len;
	logic [8*MAX_BOUNDARY-1:0] bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < 7; i++) word_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_BOUNDARY_LEN) len_q <= cfg_data[5:0];
			else word_q[cfg_index - 3'd1] <= cfg_data;
		end
	end

	// Lengths beyond the supported boundary act as the maximum.
	assign eff_len = (len_q > 6'(MAX_BOUNDARY)) ? 6'(MAX_BOUNDARY) : len_q;

	always_comb begin
		for (int i = 0; i < MAX_BOUNDARY; i++) bnd[8*i +: 8] = word_q[i/8][8*(i%8) +: 8];
	end

	logic  f_valid, f_ready, q_valid, q_ready;
	cmd_t  f_cmd, q_cmd;

	mbp_front #(.MAX_BOUNDARY(MAX_BOUNDARY)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_byte(in_byte), .chunk_last(chunk_last),
		.eff_len(eff_len), .bnd(bnd),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	mbp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	mbp_back #(.MAX_BOUNDARY(MAX_BOUNDARY)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.bnd(bnd),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .out_byte(out_byte),
		.error_offset(error_offset), .run_last(run_last)
	);

endmodule
